### sv/xrr_pkg.sv
// xrr_pkg: shared types, constants and helpers for the ranged random generator
// no dependencies; used by xrr_div and xoroshiro_ranged_random
package xrr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  // splitmix64 constants
  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_2  = 64'h94D049BB133111EB;

  localparam int unsigned MIX_SH_1 = 30;
  localparam int unsigned MIX_SH_2 = 27;
  localparam int unsigned MIX_SH_3 = 31;

  // xoroshiro128 step and starstar rotations
  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned ROT_B   = 37;
  localparam int unsigned ROT_SCR = 7;

  // mixer phase codes
  localparam logic [1:0] MIX_PH_1   = 2'd0;
  localparam logic [1:0] MIX_PH_2   = 2'd1;
  localparam logic [1:0] MIX_PH_FIN = 2'd2;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_RANGED = 2'd2
  } cmd_e;

  typedef enum logic [9:0] {
    ST_BOOT = 10'b00_0000_0001,
    ST_IDLE = 10'b00_0000_0010,
    ST_XOR  = 10'b00_0000_0100,
    ST_MUL0 = 10'b00_0000_1000,
    ST_MUL1 = 10'b00_0001_0000,
    ST_MUL2 = 10'b00_0010_0000,
    ST_SCR0 = 10'b00_0100_0000,
    ST_SCR1 = 10'b00_1000_0000,
    ST_DIV  = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [WORD_W-1:0]        seed;
    logic signed [WORD_W-1:0] range_low;
    logic signed [WORD_W-1:0] range_high;
  } xrr_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]        raw_value;
    logic signed [WORD_W-1:0] ranged_value;
  } xrr_out_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
    rotl64 = (x << k) | (x >> (64 - k));
  endfunction

endpackage

### sv/xoroshiro_ranged_random.sv
// xoroshiro_ranged_random: top level, sequencer, state words and shared multiplier
// depends on xrr_pkg and xrr_div
//
// xoroshiro128** generator with splitmix64 seeding and a ranged draw. Each input
// word carries a command: reseed (0) expands the 32-bit seed into the 128-bit state,
// raw draw (1) advances the state and returns the top 32 bits of the scrambler,
// ranged draw (2) also advances and returns lo + (raw mod span), with the bounds
// swapped when reversed; a full signed range gives lo + raw. Command 3 leaves the
// state alone and returns zeros. Exactly one output word per input word. The block
// takes one word at a time: a raw draw passes the two scrambler states and the done
// state, command 3 goes straight to done, a ranged draw with a nonzero span also waits
// on the remainder unit (it resolves one bit per cycle), and a reseed runs two
// splitmix rounds, each built from three 32x32 partial products per 64-bit multiply
// on one shared multiplier. A stalled output holds the block in its done state.
// After reset the block runs the seed-zero reseed itself and holds in_ready_o low
// until that reseed is done. A finished result waits in the output register, so the
// next input word can be accepted before it is taken.
module xoroshiro_ranged_random import xrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  xrr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output xrr_out_t out_data_o
);

  state_e state_q, state_d;

  logic [63:0]       a_q, a_d;
  logic [63:0]       b_q, b_d;
  logic [63:0]       z_q, z_d;        // mixer operand / scrambler temp
  logic [63:0]       acc_q, acc_d;    // partial product accumulator
  logic [1:0]        phase_q, phase_d;
  logic              word_q, word_d;  // which state word the mixer is building
  logic              emit_q, emit_d;  // low for the reset-time reseed
  logic [1:0]        cmd_q, cmd_d;
  logic [WORD_W-1:0] lo_q, lo_d;
  logic [WORD_W-1:0] hi_q, hi_d;
  logic [WORD_W-1:0] span_q, span_d;
  logic [WORD_W-1:0] raw_q, raw_d;
  logic [WORD_W-1:0] addend_q, addend_d;
  xrr_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // shared datapath pieces
  logic [63:0] z_xor;
  logic [63:0] mul_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] acc_hi_sum;
  logic [63:0] b_x;
  logic [63:0] scr_rot;
  logic [63:0] scr_mul9;
  logic        in_fire;
  logic        out_free;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_rem;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // xor-shift step of the mixer
  always_comb begin
    case (phase_q)
      MIX_PH_1: z_xor = z_q ^ (z_q >> MIX_SH_1);
      MIX_PH_2: z_xor = z_q ^ (z_q >> MIX_SH_2);
      default:  z_xor = z_q ^ (z_q >> MIX_SH_3);
    endcase
  end

  // one 32x32 multiplier, low 64 bits of z * c built over states MUL0, MUL1 and MUL2
  assign mul_c = (phase_q == MIX_PH_1) ? MIX_MUL_1 : MIX_MUL_2;

  always_comb begin
    case (state_q)
      ST_MUL1: begin
        mul_a = z_q[63:32];
        mul_b = mul_c[31:0];
      end
      ST_MUL2: begin
        mul_a = z_q[31:0];
        mul_b = mul_c[63:32];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end

  assign prod       = 64'(mul_a) * 64'(mul_b);
  assign acc_hi_sum = acc_q[63:32] + prod[31:0];

  // xoroshiro step and starstar scrambler (a*5 is in z_q during ST_SCR1)
  assign b_x      = b_q ^ a_q;
  assign scr_rot  = rotl64(z_q, ROT_SCR);
  assign scr_mul9 = scr_rot + {scr_rot[60:0], 3'b000};

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    z_d         = z_q;
    acc_d       = acc_q;
    phase_d     = phase_q;
    word_d      = word_q;
    emit_d      = emit_q;
    cmd_d       = cmd_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    span_d      = span_q;
    raw_d       = raw_q;
    addend_d    = addend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;

    case (state_q)
      ST_BOOT: begin
        // seed-zero reseed, no output word
        z_d     = GOLDEN_INC;
        word_d  = 1'b0;
        phase_d = MIX_PH_1;
        emit_d  = 1'b0;
        state_d = ST_XOR;
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d    = in_data_i.command;
          emit_d   = 1'b1;
          raw_d    = '0;
          addend_d = '0;
          if (in_data_i.range_low > in_data_i.range_high) begin
            lo_d = in_data_i.range_high;
            hi_d = in_data_i.range_low;
          end else begin
            lo_d = in_data_i.range_low;
            hi_d = in_data_i.range_high;
          end
          case (in_data_i.command)
            CMD_RESEED: begin
              z_d     = {32'd0, in_data_i.seed} + GOLDEN_INC;
              word_d  = 1'b0;
              phase_d = MIX_PH_1;
              state_d = ST_XOR;
            end
            CMD_RAW, CMD_RANGED: begin
              state_d = ST_SCR0;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_XOR: begin
        if (phase_q == MIX_PH_FIN) begin
          if (!word_q) begin
            // first word done, second starts from it plus the increment
            a_d     = z_xor;
            z_d     = z_xor + GOLDEN_INC;
            word_d  = 1'b1;
            phase_d = MIX_PH_1;
          end else begin
            b_d = z_xor;
            // all-zero state is not allowed
            if (a_q == 64'd0 && z_xor == 64'd0) begin
              a_d = 64'd1;
            end
            state_d = emit_q ? ST_DONE : ST_IDLE;
          end
        end else begin
          z_d     = z_xor;
          state_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        acc_d   = prod;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d   = {acc_hi_sum, acc_q[31:0]};
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        z_d     = {acc_hi_sum, acc_q[31:0]};
        phase_d = phase_q + 2'd1;
        state_d = ST_XOR;
      end
      ST_SCR0: begin
        z_d     = a_q + {a_q[61:0], 2'b00};
        a_d     = rotl64(a_q, ROT_A) ^ b_x ^ (b_x << SHIFT_B);
        b_d     = rotl64(b_x, ROT_B);
        span_d  = hi_q - lo_q + 1'b1;
        state_d = ST_SCR1;
      end
      ST_SCR1: begin
        raw_d    = scr_mul9[63:32];
        addend_d = scr_mul9[63:32];
        if (cmd_q == CMD_RANGED && span_q != '0) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          addend_d = div_rem;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.raw_value    = raw_q;
          out_d.ranged_value = (cmd_q == CMD_RANGED) ? (lo_q + addend_q) : '0;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_BOOT;
      end
    endcase
  end

  xrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scr_mul9[63:32]),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOOT;
      out_valid_q <= 1'b0;
      emit_q      <= 1'b0;
      word_q      <= 1'b0;
      phase_q     <= MIX_PH_1;
      cmd_q       <= CMD_RESEED;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      emit_q      <= emit_d;
      word_q      <= word_d;
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    z_q      <= z_d;
    acc_q    <= acc_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    span_q   <= span_d;
    raw_q    <= raw_d;
    addend_q <= addend_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(a_q == 64'd0 && b_q == 64'd0))
    else $error("generator state is all zero");

  a_div_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (span_q != '0 && cmd_q == CMD_RANGED))
    else $error("remainder unit started without a ranged draw");

  a_div_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cmd_q == CMD_RANGED))
    else $error("waiting on remainder outside a ranged draw");

  a_mix_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL0 || state_q == ST_MUL1 || state_q == ST_MUL2)
      |-> (phase_q == MIX_PH_1 || phase_q == MIX_PH_2))
    else $error("multiply issued in final mixer phase");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result dropped while output slot busy");

endmodule

### sv/xrr_div.sv
// xrr_div: restoring remainder unit, one quotient bit per cycle
// depends on xrr_pkg
module xrr_div import xrr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] rem_o
);

  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] num_q, num_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic              fits;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  always_comb begin
    shifted = {rem_q, num_q[WORD_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    fits    = shifted >= {1'b0, divisor_i};
    rem_d   = rem_q;
    num_d   = num_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      num_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      num_d = {num_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < divisor_i)
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_keeps_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q != CNT_LAST) |=> busy_q)
    else $error("divider stopped early");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done while still busy");

endmodule

### sim/tb_xoroshiro_ranged_random.sv
// tb_xoroshiro_ranged_random: self-checking testbench for the ranged random generator
// depends on xrr_pkg and xoroshiro_ranged_random; drives a directed table, then random words
module tb_xoroshiro_ranged_random;
  import xrr_pkg::*;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [31:0] S_MIN      = 32'h8000_0000;
  localparam logic [31:0] S_MAX      = 32'h7FFF_FFFF;
  localparam int          N_DIRECTED = 21;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  xrr_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  xrr_out_t out_data_o;

  xoroshiro_ranged_random dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // one row of the directed table; rows marked fixed carry the expected word typed in
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        fixed;
    logic [31:0] raw_exp;
    logic [31:0] ranged_exp;
  } stim_row_t;

  stim_row_t directed_tbl [N_DIRECTED] = '{
    // first draw after the boot-time seed-zero reseed
    '{CMD_RAW,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    // full signed range, span wraps to zero
    '{CMD_RANGED, 32'h0000_0000, S_MIN,         S_MAX,         1'b0, 32'h0, 32'h0},
    // full range with bounds reversed
    '{CMD_RANGED, 32'h0000_0000, S_MAX,         S_MIN,         1'b0, 32'h0, 32'h0},
    // single-value ranges
    '{CMD_RANGED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_RANGED, 32'h0000_0000, S_MIN,         S_MIN,         1'b0, 32'h0, 32'h0},
    '{CMD_RANGED, 32'h0000_0000, S_MAX,         S_MAX,         1'b0, 32'h0, 32'h0},
    // reversed bounds 100 .. -100
    '{CMD_RANGED, 32'h0000_0000, 32'd100,       32'hFFFF_FF9C, 1'b0, 32'h0, 32'h0},
    // widest span that does not wrap
    '{CMD_RANGED, 32'h0000_0000, S_MIN,         32'h7FFF_FFFE, 1'b0, 32'h0, 32'h0},
    '{CMD_RANGED, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_RANGED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    // unused command returns zeros, state untouched
    '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0},
    '{CMD_RAW,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    // reseed returns zeros
    '{CMD_RESEED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0},
    '{CMD_RAW,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_RESEED, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0},
    '{CMD_RAW,    32'hDEAD_BEEF, S_MIN,         S_MAX,         1'b0, 32'h0, 32'h0},
    '{CMD_RANGED, 32'h0000_0000, 32'h0000_0001, S_MAX,         1'b0, 32'h0, 32'h0},
    '{CMD_RESEED, 32'h1234_5678, 32'hFFFF_FFFF, S_MIN,         1'b1, 32'h0, 32'h0},
    '{CMD_UNUSED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0},
    '{CMD_RANGED, 32'h0000_0000, S_MIN,         32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{CMD_RAW,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0}
  };

  // generator state as the testbench sees it
  logic [63:0] gen_a;
  logic [63:0] gen_b;

  xrr_out_t pending_q [$];
  xrr_out_t oldest;
  int       send_idle_pct = 33;
  int       recv_idle_pct = 67;
  int       error_count   = 0;
  int       words_checked = 0;
  int       cmd_count [4] = '{0, 0, 0, 0};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rot_left64(input logic [63:0] x, input int unsigned k);
    logic [127:0] twice;
    twice = {x, x} << k;
    return twice[127:64];
  endfunction

  // splitmix64 finalizer
  function automatic logic [63:0] splitmix(input logic [63:0] z);
    logic [63:0] m;
    m = (z ^ (z >> MIX_SH_1)) * MIX_MUL_1;
    m = (m ^ (m >> MIX_SH_2)) * MIX_MUL_2;
    return m ^ (m >> MIX_SH_3);
  endfunction

  function automatic void seed_generator(input logic [31:0] seed);
    gen_a = splitmix({32'h0, seed} + GOLDEN_INC);
    gen_b = splitmix(gen_a + GOLDEN_INC);
    if (gen_a == 64'h0 && gen_b == 64'h0) begin
      gen_a = 64'h1;
    end
  endfunction

  // one xoroshiro128 step; returns top half of the starstar scrambler
  function automatic logic [31:0] advance_generator();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] scr;
    a     = gen_a;
    b     = gen_b ^ gen_a;
    scr   = rot_left64(a * 64'd5, ROT_SCR) * 64'd9;
    gen_a = rot_left64(a, ROT_A) ^ b ^ (b << SHIFT_B);
    gen_b = rot_left64(b, ROT_B);
    return scr[63:32];
  endfunction

  function automatic xrr_out_t predict_draw(input xrr_in_t word);
    xrr_out_t    res;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] span;
    logic [31:0] raw;
    res = '0;
    case (word.command)
      CMD_RESEED: begin
        seed_generator(word.seed);
      end
      CMD_RAW: begin
        res.raw_value = advance_generator();
      end
      CMD_RANGED: begin
        lo = word.range_low;
        hi = word.range_high;
        if ($signed(lo) > $signed(hi)) begin
          lo = word.range_high;
          hi = word.range_low;
        end
        span = hi - lo + 32'd1;
        raw  = advance_generator();
        res.raw_value = raw;
        // full signed range wraps the span to zero: plain lo + raw
        res.ranged_value = (span == 32'd0) ? lo + raw : lo + (raw % span);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [31:0] edge_bound();
    case ($urandom_range(4))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return 32'h1;
    endcase
  endfunction

  // random word: mostly draws, with bounds shaped toward small, wide and edge spans
  function automatic xrr_in_t random_word();
    xrr_in_t     w;
    int unsigned pick;
    logic [31:0] base;
    pick = $urandom_range(99);
    w.seed       = $urandom;
    w.range_low  = $urandom;
    w.range_high = $urandom;
    if (pick < 5) begin
      w.command = CMD_RESEED;
    end else if (pick < 9) begin
      w.command = CMD_UNUSED;
    end else if (pick < 38) begin
      w.command = CMD_RAW;
    end else begin
      w.command = CMD_RANGED;
      base = $urandom;
      case ($urandom_range(5))
        0: begin
          w.range_low  = base;
          w.range_high = base + $urandom_range(15);
        end
        1: begin
          w.range_low  = base + $urandom_range(300);
          w.range_high = base;
        end
        2: begin
          w.range_low  = base;
          w.range_high = base + (32'h1 << $urandom_range(31));
        end
        3: begin
          w.range_low  = edge_bound();
          w.range_high = edge_bound();
        end
        4: begin
          w.range_low  = edge_bound();
        end
        default: begin
        end
      endcase
    end
    return w;
  endfunction

  // present one word, hold it until taken, queue its expected result word
  task automatic send_word(input xrr_in_t word, input logic fixed, input xrr_out_t fixed_out);
    xrr_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_draw(word);
    pending_q.push_back(fixed ? fixed_out : predicted);
    cmd_count[word.command]++;
    @(negedge clk_i);
  endtask

  // hold the sender off until every expected result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic random_phase(input int n_words, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_words) send_word(random_word(), 1'b0, '0);
    drain();
  endtask

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker: each taken word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word raw=%h ranged=%h", $time,
                 out_data_o.raw_value, out_data_o.ranged_value);
      end else begin
        oldest = pending_q.pop_front();
        words_checked++;
        if (out_data_o.raw_value !== oldest.raw_value) begin
          error_count++;
          $display("%0t: raw_value mismatch, expected %h, got %h", $time,
                   oldest.raw_value, out_data_o.raw_value);
        end
        if (out_data_o.ranged_value !== oldest.ranged_value) begin
          error_count++;
          $display("%0t: ranged_value mismatch, expected %h, got %h", $time,
                   oldest.ranged_value, out_data_o.ranged_value);
        end
      end
    end
  end

  initial begin
    xrr_in_t   w;
    xrr_out_t  fixed_out;
    stim_row_t row;
    // the block seeds itself with zero while coming out of reset
    seed_generator(32'h0);
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table under the first idling mix
    for (int i = 0; i < N_DIRECTED; i++) begin
      row                    = directed_tbl[i];
      w.command              = row.cmd;
      w.seed                 = row.seed;
      w.range_low            = row.lo;
      w.range_high           = row.hi;
      fixed_out.raw_value    = row.raw_exp;
      fixed_out.ranged_value = row.ranged_exp;
      send_word(w, row.fixed, fixed_out);
    end
    drain();

    // sender sparse/receiver busy, then the reverse, then full speed
    random_phase(260, 33, 67);
    random_phase(260, 67, 33);
    random_phase(280, 0, 0);

    // let any stray result word show up before closing
    repeat (60) @(posedge clk_i);
    $display("covered %0d reseeds, %0d raw draws, %0d ranged draws, %0d unused commands",
             cmd_count[CMD_RESEED], cmd_count[CMD_RAW], cmd_count[CMD_RANGED],
             cmd_count[CMD_UNUSED]);
    $display("%0d result words checked, %0d mismatches", words_checked, error_count);
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout with %0d result words outstanding", pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### xoroshiro_ranged_random.f
sv/xrr_pkg.sv
sv/xrr_div.sv
sv/xoroshiro_ranged_random.sv
sim/tb_xoroshiro_ranged_random.sv
